/* rtl/lmrs_pkg.sv */
package lmrs_pkg;

    localparam int MEM_WORDS_DEF   = 4096;
    localparam int READ_SLOTS_DEF  = 8;
    localparam int WRITE_SLOTS_DEF = 16;
    localparam int ID_BITS_DEF     = 32;

    localparam int ADDR_W = 12;
    localparam int DATA_W = 64;
    localparam int QID_W  = 32;
    localparam int LAT_W  = 8;
    localparam int ACT_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_READ  = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_QUERY = 3'd3,
        CMD_PEEK  = 3'd4,
        CMD_POKE  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNTRACKED = 2'd1,
        ST_RD_HIT_WR = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_READ_LAT  = 2'd0,
        CFG_WRITE_LAT = 2'd1,
        CFG_ACT_SLOTS = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'd0,
        FSM_EXEC = 2'd1,
        FSM_OUT  = 2'd2
    } fsm_t;

    typedef struct packed {
        logic [2:0]        command;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data_in;
        logic [QID_W-1:0]  query_id;
    } in_item_t;

    typedef struct packed {
        logic              read_ready;
        logic [DATA_W-1:0] read_data;
        logic [QID_W-1:0]  issued_id;
        logic              id_pending;
        logic              slots_busy;
        logic [1:0]        status;
    } out_item_t;

endpackage

/* rtl/latency_memory_with_read_slots.sv */
// Latency memory with read slots. A request is accepted in the idle state and
// its memory read is launched on that edge. The next cycle updates the slot
// tables and drives the memory write port. The result is presented the cycle
// after that. The next request is taken the cycle after the result is taken,
// so no request is accepted while another is in flight; the pace is set by
// the synchronous memory read and the single result register. After reset
// a clearing pass writes zero to every word; no request is accepted during
// it (configuration writes are taken). Read slots and the write table are
// flop arrays searched in parallel. Tick ages both tables; a read with no
// slot captures the current word if a slot is free below the active limit;
// writes record a pending id while a write slot is free or matches.
module latency_memory_with_read_slots #(
    parameter int MEM_WORDS   = lmrs_pkg::MEM_WORDS_DEF,
    parameter int READ_SLOTS  = lmrs_pkg::READ_SLOTS_DEF,
    parameter int WRITE_SLOTS = lmrs_pkg::WRITE_SLOTS_DEF,
    parameter int ID_BITS     = lmrs_pkg::ID_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  lmrs_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output lmrs_pkg::out_item_t             m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lmrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lmrs_pkg::CFG_DATA_W-1:0] cfg_data
);
    localparam int AW  = $clog2(MEM_WORDS);
    localparam int RSW = $clog2(READ_SLOTS + 1);

    // configuration
    logic [lmrs_pkg::LAT_W-1:0] rd_lat_reg, wr_lat_reg;
    logic [lmrs_pkg::ACT_W-1:0] act_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_lat_reg <= 8'd1;
            wr_lat_reg <= 8'd1;
            act_reg    <= 4'd8;
        end else if (cfg_valid) begin
            case (cfg_index)
                lmrs_pkg::CFG_READ_LAT:  rd_lat_reg <= cfg_data;
                lmrs_pkg::CFG_WRITE_LAT: wr_lat_reg <= cfg_data;
                lmrs_pkg::CFG_ACT_SLOTS: act_reg    <= cfg_data[lmrs_pkg::ACT_W-1:0];
                default: ;
            endcase
        end
    end

    // control
    lmrs_pkg::fsm_t state_reg, state_next;
    logic [AW:0] clr_reg;
    logic clearing;
    assign clearing = !clr_reg[AW];
    lmrs_pkg::in_item_t req_reg;
    lmrs_pkg::out_item_t res_reg, res_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lmrs_pkg::FSM_IDLE: if (s_valid && s_ready) state_next = lmrs_pkg::FSM_EXEC;
            lmrs_pkg::FSM_EXEC: state_next = lmrs_pkg::FSM_OUT;
            lmrs_pkg::FSM_OUT:  if (m_ready) state_next = lmrs_pkg::FSM_IDLE;
            default:            state_next = lmrs_pkg::FSM_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == lmrs_pkg::FSM_IDLE) && !clearing;
        m_valid = (state_reg == lmrs_pkg::FSM_OUT);
    end
    assign m_data = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lmrs_pkg::FSM_IDLE;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (clearing) clr_reg <= clr_reg + 1'b1;
        end
        if (s_valid && s_ready) req_reg <= s_data;
        if (state_reg == lmrs_pkg::FSM_EXEC) res_reg <= res_next;
    end

    // memory: read issued at acceptance, data available in EXEC
    logic [AW-1:0] req_addr;
    assign req_addr = AW'(req_reg.address);
    logic [lmrs_pkg::DATA_W-1:0] mem_rdata;
    logic mem_we;
    logic [AW-1:0] mem_waddr;
    logic [lmrs_pkg::DATA_W-1:0] mem_wdata;
    logic exec;
    assign exec = (state_reg == lmrs_pkg::FSM_EXEC);

    always_comb begin
        mem_we    = clearing;
        mem_waddr = clr_reg[AW-1:0];
        mem_wdata = '0;
        if (exec && (req_reg.command == lmrs_pkg::CMD_WRITE
                     || req_reg.command == lmrs_pkg::CMD_POKE)) begin
            mem_we    = 1'b1;
            mem_waddr = req_addr;
            mem_wdata = req_reg.data_in;
        end
    end

    lmrs_mem #(.MEM_WORDS(MEM_WORDS), .AW(AW)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (AW'(s_data.address)),
        .rdata (mem_rdata)
    );

    // slot tables
    logic [READ_SLOTS-1:0]  rv_reg, rv_next;
    logic [AW-1:0]          ra_reg [READ_SLOTS];
    logic [7:0]             rr_reg [READ_SLOTS];
    logic [63:0]            rval_reg [READ_SLOTS];
    logic [WRITE_SLOTS-1:0] wv_reg, wv_next;
    logic [AW-1:0]          wa_reg [WRITE_SLOTS];
    logic [7:0]             wr_reg [WRITE_SLOTS];
    logic [ID_BITS-1:0]     wid_reg [WRITE_SLOTS];
    logic [ID_BITS-1:0]     nid_reg;

    // parallel matches
    logic [READ_SLOTS-1:0]  rhit, rfree, rclaim;
    logic [WRITE_SLOTS-1:0] whit, wfree, wsel, qhit;
    always_comb begin
        for (int i = 0; i < READ_SLOTS; i++) begin
            rhit[i]  = rv_reg[i] && (ra_reg[i] == req_addr);
            rfree[i] = !rv_reg[i];
        end
        for (int i = 0; i < WRITE_SLOTS; i++) begin
            whit[i]  = wv_reg[i] && (wa_reg[i] == req_addr);
            wfree[i] = !wv_reg[i];
            qhit[i]  = wv_reg[i]
                && (wid_reg[i] == ID_BITS'(req_reg.query_id));
        end
    end
    // lowest set bit
    assign rclaim = rfree & (~rfree + 1'b1);
    logic [WRITE_SLOTS-1:0] wfirst;
    assign wfirst = wfree & (~wfree + 1'b1);
    assign wsel   = (|whit) ? whit : wfirst;

    function automatic logic busy_of(logic [READ_SLOTS-1:0] v,
                                     logic [lmrs_pkg::ACT_W-1:0] act);
        logic [RSW-1:0] n;
        logic [RSW:0]   lim;
        n = '0;
        for (int i = 0; i < READ_SLOTS; i++) n = n + RSW'(v[i]);
        lim = ((RSW+1)'(act) > (RSW+1)'(READ_SLOTS)) ? (RSW+1)'(READ_SLOTS)
                                                      : (RSW+1)'(act);
        return (RSW+1)'(n) >= lim;
    endfunction

    logic busy_now;
    assign busy_now = busy_of(rv_reg, act_reg);

    logic rhit_ready;
    logic [63:0] rhit_val;
    always_comb begin
        rhit_ready = 1'b0;
        rhit_val   = '0;
        for (int i = 0; i < READ_SLOTS; i++) begin
            if (rhit[i] && rr_reg[i] == 8'd0) begin
                rhit_ready = 1'b1;
                rhit_val   = rval_reg[i];
            end
        end
    end

    logic do_rclaim, do_wrec;
    always_comb begin
        res_next  = '0;
        rv_next   = rv_reg;
        wv_next   = wv_reg;
        do_rclaim = 1'b0;
        do_wrec   = 1'b0;
        case (req_reg.command)
            lmrs_pkg::CMD_TICK: begin
                for (int i = 0; i < READ_SLOTS; i++)
                    if (rv_reg[i] && rr_reg[i] == 8'd0) rv_next[i] = 1'b0;
                for (int i = 0; i < WRITE_SLOTS; i++)
                    if (wv_reg[i] && wr_reg[i] == 8'd0) wv_next[i] = 1'b0;
            end
            lmrs_pkg::CMD_READ: begin
                if (|rhit) begin
                    res_next.read_ready = rhit_ready;
                    res_next.read_data  = rhit_val;
                end else if (!busy_now) begin
                    do_rclaim = 1'b1;
                    rv_next   = rv_reg | rclaim;
                    if (|whit) res_next.status = lmrs_pkg::ST_RD_HIT_WR;
                end
            end
            lmrs_pkg::CMD_WRITE: begin
                res_next.issued_id = lmrs_pkg::QID_W'(nid_reg);
                if (|wsel) begin
                    do_wrec = 1'b1;
                    wv_next = wv_reg | wsel;
                end else begin
                    res_next.status = lmrs_pkg::ST_UNTRACKED;
                end
            end
            lmrs_pkg::CMD_QUERY: res_next.id_pending = |qhit;
            lmrs_pkg::CMD_PEEK:  res_next.read_data  = mem_rdata;
            default: ;
        endcase
        res_next.slots_busy = busy_of(rv_next, act_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rv_reg  <= '0;
            wv_reg  <= '0;
            nid_reg <= '0;
        end else if (exec) begin
            rv_reg <= rv_next;
            wv_reg <= wv_next;
            if (req_reg.command == lmrs_pkg::CMD_WRITE) nid_reg <= nid_reg + 1'b1;
        end
        if (exec) begin
            for (int i = 0; i < READ_SLOTS; i++) begin
                if (req_reg.command == lmrs_pkg::CMD_TICK && rr_reg[i] != 8'd0)
                    rr_reg[i] <= rr_reg[i] - 8'd1;
                if (do_rclaim && rclaim[i]) begin
                    ra_reg[i]   <= req_addr;
                    rr_reg[i]   <= rd_lat_reg;
                    rval_reg[i] <= mem_rdata;
                end
            end
            for (int i = 0; i < WRITE_SLOTS; i++) begin
                if (req_reg.command == lmrs_pkg::CMD_TICK && wr_reg[i] != 8'd0)
                    wr_reg[i] <= wr_reg[i] - 8'd1;
                if (do_wrec && wsel[i]) begin
                    wa_reg[i]  <= req_addr;
                    wr_reg[i]  <= wr_lat_reg;
                    wid_reg[i] <= nid_reg;
                end
            end
        end
    end

    // checks
    a_no_accept_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_ready) else $error("request accepted during clear");
    a_exec_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        exec |=> m_valid) else $error("result not presented after exec");
    a_claim_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        do_rclaim |-> $onehot(rclaim)) else $error("read claim not one-hot");
    a_wsel_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        do_wrec |-> $onehot(wsel)) else $error("write slot select not one-hot");
endmodule

/* rtl/lmrs_mem.sv */
module lmrs_mem #(
    parameter int MEM_WORDS = lmrs_pkg::MEM_WORDS_DEF,
    parameter int AW        = $clog2(MEM_WORDS)
) (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [lmrs_pkg::DATA_W-1:0] wdata,
    input  logic [AW-1:0]               raddr,
    output logic [lmrs_pkg::DATA_W-1:0] rdata
);
    logic [lmrs_pkg::DATA_W-1:0] mem [MEM_WORDS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
